FILE: rtl/pmf_pkg.sv
// ----------------------------------------------------------------------------
// Pseudo-median 3x3 filter package
// Shared constants, register indexes, command codes and stage flag types.
// ----------------------------------------------------------------------------
package pmf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Register widths fixed by the register map
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 1;

    // Tallest frame supported; row counter also covers the drain row
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_BITS   = 13;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FLUSH  = 1'b1
    } cmd_t;

    // Position flags of one beat as it moves from the input stage to the core
    typedef struct packed {
        logic first_col;  // beat sits in column zero
        logic row_ge1;    // previous row is inside the frame
        logic row_ge2;    // row two above is inside the frame
        logic emit;       // beat completes a result
        logic last;       // result closes the frame
    } pos_flags_t;

endpackage

FILE: rtl/pseudo_median_3x3_filter.sv
// ----------------------------------------------------------------------------
// Pseudo-median 3x3 filter
// Median of three column medians over a raster-order plane, zero border.
// ----------------------------------------------------------------------------
// Usage:
//   Write frame_width (index 0) and frame_height (index 1) through the cfg
//   port while the block is idle; each write restarts the frame position.
//   Send the plane's samples in raster order on the input channel
//   (command = sample), then frame_width+1 flush beats to drain it.
//   Each result belongs to the pixel one row and one column behind the
//   input; frame_end marks the last pixel of the frame, after which the
//   next beat starts a new frame.
//   Throughput: one beat per cycle unless the output stalls. The line
//   store is a single memory with one read and one write port; the read
//   for a beat is issued at accept, so the line data enters the core stage with the beat.
//   Path: the beat that completes a result is registered in the core
//   stage, and the result is then registered in the output register.
//   Stall: while the output register holds an untaken result, the core
//   stage holds; in_ready stays high as long as the core stage can drain.
//   Reset: sizes return to 1x1, position to the frame start, both stages
//   empty. The line store is not cleared: rows not yet written in the
//   current frame are masked to zero.
// ----------------------------------------------------------------------------
module pseudo_median_3x3_filter #(
    parameter int MAX_WIDTH   = pmf_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = pmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [pmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic signed [SAMPLE_BITS-1:0]      sample_value,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      filtered_value,
    output logic                               frame_end
);
    import pmf_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t upper;
        sample_t lower;
    } line_pair_t;

    function automatic sample_t med3(sample_t a, sample_t b, sample_t c);
        sample_t lo;
        sample_t hi;
        sample_t m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // configuration and position
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]        col_reg;
    logic [ROW_BITS-1:0]        row_reg;
    logic [COL_BITS-1:0]        last_col;
    logic [ROW_BITS-1:0]        eff_height;
    logic [ROW_BITS-1:0]        end_row;

    // core stage
    logic                       s1_valid_reg;
    pos_flags_t                 s1_flags_reg;
    pos_flags_t                 flags_next;
    logic [COL_BITS-1:0]        s1_col_reg;
    sample_t                    s1_cur_reg;
    sample_t                    cur_next;
    line_pair_t                 rd_q_reg;
    logic                       fwd_reg;
    line_pair_t                 fwd_data_reg;
    line_pair_t                 line_mem [MAX_WIDTH];

    // column medians of the left and center columns of the pending pixel's window
    sample_t                    med_c_reg;
    sample_t                    med_r_reg;

    // output register
    logic                       out_valid_reg;
    sample_t                    filtered_reg;
    logic                       frame_end_reg;

    logic                       in_fire;
    logic                       s1_go;
    logic                       at_end;
    line_pair_t                 rd;
    line_pair_t                 wr_data;
    sample_t                    top;
    sample_t                    mid;
    sample_t                    col_med;
    sample_t                    right_med;
    sample_t                    result;

    // ------------------------------------------------------------------
    // Effective frame size
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_BITS'(width_reg - 1'b1);
        end

        if (height_reg == '0)
        begin
            eff_height = ROW_BITS'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_height = ROW_BITS'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = ROW_BITS'(height_reg);
        end

        // the last result arrives on the first beat of the drain row
        end_row = eff_height + 1'b1;
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Input stage: position flags and the sample that enters the window
    // ------------------------------------------------------------------
    always_comb
    begin
        at_end               = (row_reg == end_row) && (col_reg == '0);
        flags_next.first_col = (col_reg == '0);
        flags_next.row_ge1   = (row_reg != '0);
        flags_next.row_ge2   = (row_reg >= ROW_BITS'(2));
        flags_next.emit      = flags_next.row_ge2 ||
                               (flags_next.row_ge1 && !flags_next.first_col);
        flags_next.last      = at_end;
        // flush beats and beats past the last row feed zero
        if (command == CMD_SAMPLE && row_reg < eff_height)
        begin
            cur_next = sample_value;
        end
        else
        begin
            cur_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Core stage: column median and median of medians
    // ------------------------------------------------------------------
    always_comb
    begin
        rd        = fwd_reg ? fwd_data_reg : rd_q_reg;
        top       = s1_flags_reg.row_ge2 ? rd.upper : '0;
        mid       = s1_flags_reg.row_ge1 ? rd.lower : '0;
        wr_data   = '{upper: rd.lower, lower: s1_cur_reg};
        col_med   = med3(top, mid, s1_cur_reg);
        // at column zero the pending pixel is the previous row's last one,
        // which sees a zero column on its right
        right_med = s1_flags_reg.first_col ? '0 : col_med;
        result    = med3(med_c_reg, med_r_reg, right_med);
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_REG_BITS'(1);
            height_reg    <= HEIGHT_REG_BITS'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_BITS-1:0];
                    default:          ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_fire)
            begin
                if (at_end)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (col_reg == last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && s1_flags_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: read at accept, write back from the core stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
        if (in_fire)
        begin
            rd_q_reg <= line_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flags_reg <= flags_next;
            s1_col_reg   <= col_reg;
            s1_cur_reg   <= cur_next;
            // same column written by the beat leaving the core: bypass it
            fwd_reg      <= s1_go && (s1_col_reg == col_reg);
            fwd_data_reg <= wr_data;
        end

        if (s1_go)
        begin
            med_c_reg <= s1_flags_reg.first_col ? '0 : med_r_reg;
            med_r_reg <= col_med;
            if (s1_flags_reg.emit)
            begin
                filtered_reg  <= result;
                frame_end_reg <= s1_flags_reg.last;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filtered_reg;
    assign frame_end      = frame_end_reg;

`ifndef SYNTHESIS
    // column counter never leaves the frame
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= last_col)
        else $error("column position beyond frame width");

    // row counter never passes the drain row
    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= end_row)
        else $error("row position beyond drain row");

    // the beat that closes the frame returns the position to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && at_end && !cfg_we) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not restarted after frame end");

    // a stalled core stage must block new beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while core stage is stalled");
`endif

endmodule

FILE: tb/sv/pseudo_median_3x3_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pseudo-median 3x3 filter testbench
// Streams raster-order planes of many sizes through the filter. A window model
// inside the scoreboard predicts every output pixel and checks each output
// beat in order. Both channels idle and stall at random, with one long output
// stall.
// ----------------------------------------------------------------------------
module pseudo_median_3x3_filter_tb;
    import pmf_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int TARGET_BEATS  = 1000;
    localparam int REPORT_LIMIT  = 10;

    typedef logic signed [SB-1:0] sample_t;

    typedef struct {
        sample_t value;
        logic    last;
    } pixel_t;

    class median_scoreboard;
        logic [WIDTH_REG_BITS-1:0]  width_reg;
        logic [HEIGHT_REG_BITS-1:0] height_reg;
        sample_t     upper_line [LINE_DEPTH];
        sample_t     lower_line [LINE_DEPTH];
        sample_t     window [9];    // column-major: left column first, top row first
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned pixels_done;
        pixel_t      pending_pixels [$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            width_reg  = 1;
            height_reg = 1;
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            mismatches = 0;
            checked    = 0;
            restart();
        endfunction

        function void restart();
            col_pos     = 0;
            row_pos     = 0;
            pixels_done = 0;
        endfunction

        function int unsigned active_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > LINE_DEPTH)
                return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned active_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > MAX_HEIGHT)
                return MAX_HEIGHT;
            return height_reg;
        endfunction

        function sample_t middle_of(sample_t a, sample_t b, sample_t c);
            sample_t lo;
            sample_t hi;
            sample_t m;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            m  = (hi < c) ? hi : c;
            return (lo > m) ? lo : m;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Any register write drops the frame in progress
        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[WIDTH_REG_BITS-1:0];
                REG_FRAME_HEIGHT: height_reg = data[HEIGHT_REG_BITS-1:0];
                default: ;
            endcase
            restart();
        endfunction

        function void note_beat(cmd_t cmd, sample_t smp);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            sample_t     cur;
            sample_t     top;
            sample_t     mid;
            sample_t     m0;
            sample_t     m1;
            sample_t     m2;
            logic        emit;
            pixel_t      px;
            w = active_width();
            h = active_height();
            c = (col_pos >= w) ? 0 : col_pos;
            r = row_pos;
            // flushes and anything past the last row enter as zero
            cur = (cmd == CMD_SAMPLE && r < h) ? smp : '0;
            top = (r >= 2) ? upper_line[c] : '0;
            mid = (r >= 1) ? lower_line[c] : '0;
            upper_line[c] = lower_line[c];
            lower_line[c] = cur;
            emit = (r >= 2) || (r == 1 && c >= 1);
            if (c >= 1)
            begin
                for (int k = 0; k < 6; k++)
                    window[k] = window[k + 3];
                window[6] = top;
                window[7] = mid;
                window[8] = cur;
                m0 = middle_of(window[0], window[1], window[2]);
                m1 = middle_of(window[3], window[4], window[5]);
                m2 = middle_of(window[6], window[7], window[8]);
            end
            else
            begin
                // row wrap: last pixel of the previous row sees a zero column on its right
                m0 = middle_of(window[3], window[4], window[5]);
                m1 = middle_of(window[6], window[7], window[8]);
                m2 = '0;
                for (int k = 0; k < 3; k++)
                    window[k] = window[k + 6];
                window[3] = '0;
                window[4] = '0;
                window[5] = '0;
                window[6] = top;
                window[7] = mid;
                window[8] = cur;
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r % (1 << ROW_BITS);
            if (!emit)
                return;
            px.value = middle_of(m0, m1, m2);
            px.last  = (pixels_done + 1 >= w * h);
            pending_pixels.push_back(px);
            if (px.last)
                restart();
            else
                pixels_done = (pixels_done + 1) % (1 << 23);
        endfunction

        function void flag(string what, sample_t want_v, logic want_l,
                           sample_t got_v, logic got_l);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%t ERROR %s: expected value %0d end %0b, got value %0d end %0b",
                         $realtime, what, want_v, want_l, got_v, got_l);
        endfunction

        function void check_beat(sample_t value, logic last);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                flag("unexpected output beat", '0, 1'b0, value, last);
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (value !== want.value || last !== want.last)
                flag("output mismatch", want.value, want.last, value, last);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      command;
    sample_t                   sample_value;
    logic                      out_valid;
    logic                      out_ready;
    sample_t                   filtered_value;
    logic                      frame_end;

    median_scoreboard sb;
    bit               steady      = 1'b0;
    bit               hold_output = 1'b0;
    int unsigned      beats_sent  = 0;
    int unsigned      frames      = 0;
    int unsigned      idle_cycles = 0;

    pseudo_median_3x3_filter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .frame_end      (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t random_sample();
        logic [31:0] r;
        r = $urandom;
        return r[SB-1:0];
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(cmd_t cmd, sample_t smp);
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_value <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(cmd, smp);
        beats_sent++;
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        drain_outputs();
        // first-row beats leave no result behind, so give the pipeline time to empty
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(w);
        @(posedge clk);
        sb.write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_BITS'(h);
        @(posedge clk);
        sb.write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
        cfg_we <= 1'b0;
        @(posedge clk);
        frames++;
    endtask

    task automatic send_frame(int unsigned w, int unsigned h);
        int unsigned n;
        for (n = 0; n < w * h; n++)
        begin
            if ($urandom_range(99) < 2)
                drain_outputs();
            if ($urandom_range(99) < 4)
                send_beat(CMD_FLUSH, random_sample());
            else
                send_beat(CMD_SAMPLE, random_sample());
        end
        // drain: a stray sample here counts as a flush
        for (n = 0; n <= w; n++)
            send_beat(($urandom_range(99) < 8) ? CMD_SAMPLE : CMD_FLUSH, random_sample());
    endtask

    task automatic send_noise(int unsigned count);
        repeat (count)
            send_beat($urandom_range(1) ? CMD_FLUSH : CMD_SAMPLE, random_sample());
    endtask

    // Output side: random stalls plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_beat(filtered_value, frame_end);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%t watchdog: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles++;
    end

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        int unsigned ew;
        int unsigned eh;
        sb = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_SAMPLE;
        sample_value <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_data     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1 frame straight out of reset
        send_beat(CMD_SAMPLE, 16'sh7fff);
        send_beat(CMD_FLUSH, '0);
        send_beat(CMD_FLUSH, '0);

        // 3x3 frame with extreme samples, a flush inside and a sample in the drain
        set_frame(3, 3);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh7fff);
        send_beat(CMD_SAMPLE, 16'sh0000);
        send_beat(CMD_SAMPLE, -16'sd1);
        send_beat(CMD_SAMPLE, 16'sd1);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh7fff);
        send_beat(CMD_FLUSH, 16'sh1234);
        send_beat(CMD_SAMPLE, -16'sd2);
        send_beat(CMD_FLUSH, 16'sh8000);
        send_beat(CMD_FLUSH, 16'sh7fff);
        send_beat(CMD_SAMPLE, 16'sh7fff);
        send_beat(CMD_FLUSH, '0);

        // zero sizes behave as 1x1
        set_frame(0, 0);
        send_beat(CMD_SAMPLE, -16'sd1);
        send_beat(CMD_FLUSH, '0);
        send_beat(CMD_FLUSH, '0);

        // fill the block against a stalled output
        set_frame(8, 6);
        hold_output = 1'b1;
        send_frame(8, 6);

        while (beats_sent < TARGET_BEATS)
        begin
            steady = (beats_sent >= 400 && beats_sent < 600);
            pick   = $urandom_range(99);
            w      = $urandom_range(1, 10);
            h      = $urandom_range(1, 6);
            if (pick < 80)
            begin
                set_frame(w, h);
                send_frame(w, h);
            end
            else if (pick < 90)
            begin
                set_frame(w, h);
                send_noise($urandom_range(1, 2 * w * h + w));
            end
            else
            begin
                // oversized, maximum, zero or unit sizes; abandon the frame after a few beats
                case ($urandom_range(2))
                    0:       ew = (1 << CFG_DATA_BITS) - 1;
                    1:       ew = LINE_DEPTH;
                    default: ew = 0;
                endcase
                case ($urandom_range(3))
                    0:       eh = (1 << CFG_DATA_BITS) - 1;
                    1:       eh = MAX_HEIGHT;
                    2:       eh = 0;
                    default: eh = 1;
                endcase
                set_frame(ew, eh);
                send_noise($urandom_range(5, 30));
            end
        end
        steady = 1'b0;

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d input beats over %0d size settings; %0d output pixels checked.",
                 beats_sent, frames, sb.checked);
        $display("Sizes ran from zero to oversized, with a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
